/* sv/spd_pkg.sv */
package spd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int COORD_SHIFT = (COORD_WIDTH > 30) ? 1 : 0;
    localparam int MAG_W       = COORD_WIDTH + 1 - COORD_SHIFT;
    localparam int DIFF_W      = MAG_W + 1;
    localparam int ROOT_W      = MAG_W + 1;
    localparam int SUM_W       = 2 * ROOT_W;
    localparam int NMAG_W      = DIFF_W + 16;
    localparam int FACE_W      = 16;
    localparam int FROOT_W     = 16;
    localparam int FSUM_W      = 2 * FROOT_W;
    localparam int PROD_W      = ROOT_W + FROOT_W;
    localparam int QUOT_W      = 18;
    localparam int PDIV_W      = PROD_W + QUOT_W;
    localparam int LIMIT_W     = 23;
    localparam int ROLL_W      = 16;
    localparam int SCALED_W    = LIMIT_W + ROLL_W;
    localparam int ADIV_W      = SCALED_W + QUOT_W;
    localparam int GAIN_W      = 16;
    localparam int HROOT_W     = 16;
    localparam int HSUM_W      = 2 * HROOT_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [GAIN_W:0] UNITY = 17'd32768;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LISTENER_X = 3'd0,
        CFG_LISTENER_Y = 3'd1,
        CFG_LISTENER_Z = 3'd2,
        CFG_FACING_X   = 3'd3,
        CFG_FACING_Z   = 3'd4,
        CFG_ROLLOFF    = 3'd5,
        CFG_FAR_LIMIT  = 3'd6,
        CFG_NEAR_LIMIT = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] source_x;
        logic signed [COORD_WIDTH-1:0] source_y;
        logic signed [COORD_WIDTH-1:0] source_z;
    } t_src;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_left;
        logic [GAIN_W-1:0] gain_right;
    } t_gain;

endpackage

/* sv/spd_sqrt_cell.sv */
module spd_sqrt_cell #(
    parameter int VW   = 32,
    parameter int STEP = 0,
    parameter int PW   = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [VW-1:0] i_val,
    input  logic [VW-1:0] i_root,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [VW-1:0] o_val,
    output logic [VW-1:0] o_root,
    output logic [PW-1:0] o_side
);

    localparam logic [VW-1:0] BIT = VW'(1) << (2 * STEP);

    logic          r_valid;
    logic [VW-1:0] r_val;
    logic [VW-1:0] r_root;
    logic [PW-1:0] r_side;
    logic [VW-1:0] n_val;
    logic [VW-1:0] n_root;
    logic [VW-1:0] trial;

    always_comb begin
        trial = i_root + BIT;
        if (i_val >= trial) begin
            n_val  = i_val - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_val  = i_val;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= n_val;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_val   = r_val;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

/* sv/spd_div_cell.sv */
module spd_div_cell #(
    parameter int NW   = 64,
    parameter int QW   = 18,
    parameter int STEP = 0,
    parameter int PW   = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rem,
    input  logic [NW-1:0] i_den,
    input  logic [QW-1:0] i_quot,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_rem,
    output logic [NW-1:0] o_den,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_side
);

    logic          r_valid;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic [PW-1:0] r_side;
    logic [NW-1:0] n_rem;
    logic [QW-1:0] n_quot;
    logic [NW-1:0] shifted;

    always_comb begin
        shifted = i_den << STEP;
        if (i_rem >= shifted) begin
            n_rem  = i_rem - shifted;
            n_quot = i_quot | (QW'(1) << STEP);
        end else begin
            n_rem  = i_rem;
            n_quot = i_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule

/* sv/stereo_distance_panner.sv */
// Channel   Direction  Handshake                   Payload
// source    in         i_valid / o_stall           i_src  (spd_pkg::t_src)
// gains     out        o_valid / i_stall           o_gain (spd_pkg::t_gain)
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while o_stall is low; o_valid rises once an accepted
// item has passed stages 1 to 3, the distance root cell row, stages 4 and 5, the divider
// cell rows, stage 6, the gain root cell rows, stage 7 and the output register.
// Reset is synchronous and active low; it restores the register defaults and
// empties the pipeline. A stalled output holds the pipeline once its skid entry fills.
module stereo_distance_panner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  spd_pkg::t_src                       i_src,
    output logic                                o_valid,
    input  logic                                i_stall,
    output spd_pkg::t_gain                      o_gain,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW      = spd_pkg::COORD_WIDTH;
    localparam int SH      = spd_pkg::COORD_SHIFT;
    localparam int MAG_W   = spd_pkg::MAG_W;
    localparam int DIFF_W  = spd_pkg::DIFF_W;
    localparam int ROOT_W  = spd_pkg::ROOT_W;
    localparam int SUM_W   = spd_pkg::SUM_W;
    localparam int NMAG_W  = spd_pkg::NMAG_W;
    localparam int FACE_W  = spd_pkg::FACE_W;
    localparam int FROOT_W = spd_pkg::FROOT_W;
    localparam int FSUM_W  = spd_pkg::FSUM_W;
    localparam int PROD_W  = spd_pkg::PROD_W;
    localparam int QUOT_W  = spd_pkg::QUOT_W;
    localparam int PDIV_W  = spd_pkg::PDIV_W;
    localparam int LIMIT_W = spd_pkg::LIMIT_W;
    localparam int ROLL_W  = spd_pkg::ROLL_W;
    localparam int SCALED_W = spd_pkg::SCALED_W;
    localparam int ADIV_W  = spd_pkg::ADIV_W;
    localparam int GAIN_W  = spd_pkg::GAIN_W;
    localparam int HROOT_W = spd_pkg::HROOT_W;
    localparam int HSUM_W  = spd_pkg::HSUM_W;
    localparam int DIST_W  = ROOT_W + SH;
    localparam int CMP_W   = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

    // Configuration registers.
    logic signed [CW-1:0]     r_lx, r_ly, r_lz;
    logic signed [FACE_W-1:0] r_fx, r_fz;
    logic [ROLL_W-1:0]        r_roll;
    logic [LIMIT_W-1:0]       r_far, r_near;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx   <= '0;
            r_ly   <= '0;
            r_lz   <= '0;
            r_fx   <= '0;
            r_fz   <= 16'sh8000;
            r_roll <= 16'd256;
            r_far  <= 23'd204800;
            r_near <= 23'd4096;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (spd_pkg::t_cfg_index'(i_cfg_index))
                spd_pkg::CFG_LISTENER_X: r_lx   <= i_cfg_data[CW-1:0];
                spd_pkg::CFG_LISTENER_Y: r_ly   <= i_cfg_data[CW-1:0];
                spd_pkg::CFG_LISTENER_Z: r_lz   <= i_cfg_data[CW-1:0];
                spd_pkg::CFG_FACING_X:   r_fx   <= i_cfg_data[FACE_W-1:0];
                spd_pkg::CFG_FACING_Z:   r_fz   <= i_cfg_data[FACE_W-1:0];
                spd_pkg::CFG_ROLLOFF:    r_roll <= i_cfg_data[ROLL_W-1:0];
                spd_pkg::CFG_FAR_LIMIT:  r_far  <= i_cfg_data[LIMIT_W-1:0];
                spd_pkg::CFG_NEAR_LIMIT: r_near <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [DIFF_W-1:0] shrink_diff(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] d;
        logic [CW:0]        m;
        logic [DIFF_W-1:0]  mm;
        d  = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        m  = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
        mm = DIFF_W'(m >> SH);
        return d[CW] ? $signed(-mm) : $signed(mm);
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m[MAG_W-1:0];
    endfunction

    logic en;
    logic r_skid_valid;
    logic r_out_valid;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Stage 1: offsets from the listener.
    logic                     r_s1_valid;
    logic signed [DIFF_W-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    logic [MAG_W-1:0]         r_s1_ax, r_s1_ay, r_s1_az;
    logic signed [DIFF_W-1:0] dx, dy, dz;

    assign dx = shrink_diff(i_src.source_x, r_lx);
    assign dy = shrink_diff(i_src.source_y, r_ly);
    assign dz = shrink_diff(i_src.source_z, r_lz);

    // Stage 2: squares and cross products.
    logic                         r_s2_valid;
    logic [2*MAG_W-1:0]           r_s2_sqx, r_s2_sqy, r_s2_sqz;
    logic signed [DIFF_W+15:0]    r_s2_px, r_s2_pz;

    // Stage 3: squared distance and pan numerator.
    logic                         r_s3_valid;
    logic [SUM_W-1:0]             r_s3_sum;
    logic                         r_s3_sign;
    logic [NMAG_W-1:0]            r_s3_nmag;
    logic signed [DIFF_W+16:0]    num;

    assign num = (DIFF_W+17)'(r_s2_px) - (DIFF_W+17)'(r_s2_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dx   <= dx;
            r_s1_dy   <= dy;
            r_s1_dz   <= dz;
            r_s1_ax   <= mag_of(dx);
            r_s1_ay   <= mag_of(dy);
            r_s1_az   <= mag_of(dz);
            r_s2_sqx  <= r_s1_ax * r_s1_ax;
            r_s2_sqy  <= r_s1_ay * r_s1_ay;
            r_s2_sqz  <= r_s1_az * r_s1_az;
            r_s2_px   <= r_s1_dx * r_fz;
            r_s2_pz   <= r_s1_dz * r_fx;
            r_s3_sum  <= SUM_W'(r_s2_sqx) + SUM_W'(r_s2_sqy) + SUM_W'(r_s2_sqz);
            r_s3_sign <= num[DIFF_W+16];
            r_s3_nmag <= num[DIFF_W+16] ? NMAG_W'(-num) : NMAG_W'(num);
        end
    end

    // Distance root cell row.
    logic              m_valid [0:ROOT_W];
    logic [SUM_W-1:0]  m_val   [0:ROOT_W];
    logic [SUM_W-1:0]  m_root  [0:ROOT_W];
    logic [NMAG_W:0]   m_side  [0:ROOT_W];

    assign m_valid[0] = r_s3_valid;
    assign m_val[0]   = r_s3_sum;
    assign m_root[0]  = '0;
    assign m_side[0]  = {r_s3_sign, r_s3_nmag};

    for (genvar k = 0; k < ROOT_W; k++) begin : g_dist_root
        spd_sqrt_cell #(.VW(SUM_W), .STEP(ROOT_W-1-k), .PW(NMAG_W+1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (m_valid[k]),
            .i_val   (m_val[k]),
            .i_root  (m_root[k]),
            .i_side  (m_side[k]),
            .o_valid (m_valid[k+1]),
            .o_val   (m_val[k+1]),
            .o_root  (m_root[k+1]),
            .o_side  (m_side[k+1])
        );
    end

    // Length of the right vector, kept up to date from the facing registers.
    logic                     r_fsum_nz;
    logic [FSUM_W-1:0]        r_fsum;
    logic signed [FSUM_W-1:0] fxx, fzz;
    logic                     f_valid [0:FROOT_W];
    logic [FSUM_W-1:0]        f_val   [0:FROOT_W];
    logic [FSUM_W-1:0]        f_root  [0:FROOT_W];
    logic                     f_side  [0:FROOT_W];

    assign fxx = r_fx * r_fx;
    assign fzz = r_fz * r_fz;

    always_ff @(posedge i_clk) begin
        r_fsum    <= $unsigned(fxx) + $unsigned(fzz);
        r_fsum_nz <= (r_fx != '0) || (r_fz != '0);
    end

    assign f_valid[0] = 1'b1;
    assign f_val[0]   = r_fsum;
    assign f_root[0]  = '0;
    assign f_side[0]  = r_fsum_nz;

    for (genvar k = 0; k < FROOT_W; k++) begin : g_face_root
        spd_sqrt_cell #(.VW(FSUM_W), .STEP(FROOT_W-1-k), .PW(1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (1'b1),
            .i_valid (f_valid[k]),
            .i_val   (f_val[k]),
            .i_root  (f_root[k]),
            .i_side  (f_side[k]),
            .o_valid (f_valid[k+1]),
            .o_val   (f_val[k+1]),
            .o_root  (f_root[k+1]),
            .o_side  (f_side[k+1])
        );
    end

    // Stage 4: clamped distance times rolloff, and the pan denominator.
    logic [ROOT_W-1:0]   draw;
    logic [CMP_W-1:0]    dist_full;
    logic [LIMIT_W-1:0]  lim;
    logic                r_s4_valid;
    logic [SCALED_W-1:0] r_s4_scaled;
    logic [PROD_W-1:0]   r_s4_prod;
    logic                r_s4_sign;
    logic                r_s4_pzero;
    logic [NMAG_W-1:0]   r_s4_nmag;

    assign draw      = m_root[ROOT_W][ROOT_W-1:0];
    assign dist_full = CMP_W'(draw) << SH;
    assign lim       = (dist_full < CMP_W'(r_far)) ? dist_full[LIMIT_W-1:0] : r_far;

    // Stage 5: attenuation denominator.
    logic                r_s5_valid;
    logic [SCALED_W-1:0] r_s5_den;
    logic                r_s5_dzero;
    logic [PROD_W-1:0]   r_s5_prod;
    logic                r_s5_sign;
    logic                r_s5_pzero;
    logic [NMAG_W-1:0]   r_s5_nmag;
    logic [SCALED_W-1:0] refq;

    assign refq = SCALED_W'({r_near, 8'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= m_valid[ROOT_W];
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_scaled <= lim * r_roll;
            r_s4_prod   <= draw * f_root[FROOT_W][FROOT_W-1:0];
            r_s4_sign   <= m_side[ROOT_W][NMAG_W];
            r_s4_nmag   <= m_side[ROOT_W][NMAG_W-1:0];
            r_s4_pzero  <= (draw == '0) || !f_side[FROOT_W];
            r_s5_den    <= (r_s4_scaled > refq) ? r_s4_scaled : refq;
            r_s5_dzero  <= (r_s4_scaled == '0) && (r_near == '0);
            r_s5_prod   <= r_s4_prod;
            r_s5_sign   <= r_s4_sign;
            r_s5_pzero  <= r_s4_pzero;
            r_s5_nmag   <= r_s4_nmag;
        end
    end

    // Divider cell rows: attenuation and pan.
    logic              a_valid [0:QUOT_W];
    logic [ADIV_W-1:0] a_rem   [0:QUOT_W];
    logic [ADIV_W-1:0] a_den   [0:QUOT_W];
    logic [QUOT_W-1:0] a_quot  [0:QUOT_W];
    logic              a_side  [0:QUOT_W];
    logic              p_valid [0:QUOT_W];
    logic [PDIV_W-1:0] p_rem   [0:QUOT_W];
    logic [PDIV_W-1:0] p_den   [0:QUOT_W];
    logic [QUOT_W-1:0] p_quot  [0:QUOT_W];
    logic [1:0]        p_side  [0:QUOT_W];

    assign a_valid[0] = r_s5_valid;
    assign a_rem[0]   = ADIV_W'({r_near, 23'b0});
    assign a_den[0]   = ADIV_W'(r_s5_den);
    assign a_quot[0]  = '0;
    assign a_side[0]  = r_s5_dzero;
    assign p_valid[0] = r_s5_valid;
    assign p_rem[0]   = PDIV_W'({r_s5_nmag, 15'b0});
    assign p_den[0]   = PDIV_W'(r_s5_prod);
    assign p_quot[0]  = '0;
    assign p_side[0]  = {r_s5_sign, r_s5_pzero};

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        spd_div_cell #(.NW(ADIV_W), .QW(QUOT_W), .STEP(QUOT_W-1-k), .PW(1)) u_att (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (a_valid[k]),
            .i_rem   (a_rem[k]),
            .i_den   (a_den[k]),
            .i_quot  (a_quot[k]),
            .i_side  (a_side[k]),
            .o_valid (a_valid[k+1]),
            .o_rem   (a_rem[k+1]),
            .o_den   (a_den[k+1]),
            .o_quot  (a_quot[k+1]),
            .o_side  (a_side[k+1])
        );
        spd_div_cell #(.NW(PDIV_W), .QW(QUOT_W), .STEP(QUOT_W-1-k), .PW(2)) u_pan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (p_valid[k]),
            .i_rem   (p_rem[k]),
            .i_den   (p_den[k]),
            .i_quot  (p_quot[k]),
            .i_side  (p_side[k]),
            .o_valid (p_valid[k+1]),
            .o_rem   (p_rem[k+1]),
            .o_den   (p_den[k+1]),
            .o_quot  (p_quot[k+1]),
            .o_side  (p_side[k+1])
        );
    end

    // Stage 6: attenuation, pan and the two half weights.
    logic [GAIN_W-1:0] att;
    logic [GAIN_W:0]   pm;
    logic [GAIN_W+1:0] up, dn;
    logic              pan_neg;
    logic              r_s6_valid;
    logic [GAIN_W-1:0] r_s6_att;
    logic [GAIN_W-1:0] r_s6_hl, r_s6_hr;

    always_comb begin
        if (a_side[QUOT_W] || (a_quot[QUOT_W] > QUOT_W'(spd_pkg::UNITY))) begin
            att = spd_pkg::UNITY[GAIN_W-1:0];
        end else begin
            att = a_quot[QUOT_W][GAIN_W-1:0];
        end
        if (p_side[QUOT_W][0]) begin
            pm = '0;
        end else if (p_quot[QUOT_W] > QUOT_W'(spd_pkg::UNITY)) begin
            pm = spd_pkg::UNITY;
        end else begin
            pm = p_quot[QUOT_W][GAIN_W:0];
        end
        pan_neg = p_side[QUOT_W][1];
        up = (GAIN_W+2)'(spd_pkg::UNITY) + (GAIN_W+2)'(pm);
        dn = (GAIN_W+2)'(spd_pkg::UNITY) - (GAIN_W+2)'(pm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (en) begin
            r_s6_valid <= a_valid[QUOT_W] && p_valid[QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_att <= att;
            r_s6_hl  <= pan_neg ? up[GAIN_W:1] : dn[GAIN_W:1];
            r_s6_hr  <= pan_neg ? dn[GAIN_W:1] : up[GAIN_W:1];
        end
    end

    // Constant-power root cell rows, one per channel.
    logic              l_valid [0:HROOT_W];
    logic [HSUM_W-1:0] l_val   [0:HROOT_W];
    logic [HSUM_W-1:0] l_root  [0:HROOT_W];
    logic [GAIN_W-1:0] l_side  [0:HROOT_W];
    logic              g_valid [0:HROOT_W];
    logic [HSUM_W-1:0] g_val   [0:HROOT_W];
    logic [HSUM_W-1:0] g_root  [0:HROOT_W];
    logic [GAIN_W-1:0] g_side  [0:HROOT_W];

    assign l_valid[0] = r_s6_valid;
    assign l_val[0]   = HSUM_W'({r_s6_hl, 15'b0});
    assign l_root[0]  = '0;
    assign l_side[0]  = r_s6_att;
    assign g_valid[0] = r_s6_valid;
    assign g_val[0]   = HSUM_W'({r_s6_hr, 15'b0});
    assign g_root[0]  = '0;
    assign g_side[0]  = r_s6_att;

    for (genvar k = 0; k < HROOT_W; k++) begin : g_gain_root
        spd_sqrt_cell #(.VW(HSUM_W), .STEP(HROOT_W-1-k), .PW(GAIN_W)) u_left (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (l_valid[k]),
            .i_val   (l_val[k]),
            .i_root  (l_root[k]),
            .i_side  (l_side[k]),
            .o_valid (l_valid[k+1]),
            .o_val   (l_val[k+1]),
            .o_root  (l_root[k+1]),
            .o_side  (l_side[k+1])
        );
        spd_sqrt_cell #(.VW(HSUM_W), .STEP(HROOT_W-1-k), .PW(GAIN_W)) u_right (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (g_valid[k]),
            .i_val   (g_val[k]),
            .i_root  (g_root[k]),
            .i_side  (g_side[k]),
            .o_valid (g_valid[k+1]),
            .o_val   (g_val[k+1]),
            .o_root  (g_root[k+1]),
            .o_side  (g_side[k+1])
        );
    end

    // Stage 7: scale by the attenuation.
    logic                 r_s7_valid;
    logic [2*GAIN_W-1:0]  r_s7_gl, r_s7_gr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid <= l_valid[HROOT_W] && g_valid[HROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_gl <= l_root[HROOT_W][HROOT_W-1:0] * l_side[HROOT_W];
            r_s7_gr <= g_root[HROOT_W][HROOT_W-1:0] * g_side[HROOT_W];
        end
    end

    // Saturation, output register and skid entry.
    spd_pkg::t_gain exit_gain;
    logic           exit_valid;
    spd_pkg::t_gain r_out;
    spd_pkg::t_gain r_skid;

    always_comb begin
        exit_gain.gain_left  = (r_s7_gl[2*GAIN_W-1:15] > spd_pkg::UNITY) ?
                               spd_pkg::UNITY[GAIN_W-1:0] : r_s7_gl[GAIN_W+14:15];
        exit_gain.gain_right = (r_s7_gr[2*GAIN_W-1:15] > spd_pkg::UNITY) ?
                               spd_pkg::UNITY[GAIN_W-1:0] : r_s7_gr[GAIN_W+14:15];
    end

    assign exit_valid = r_s7_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= exit_valid;
            end
        end else if (exit_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : exit_gain;
        end else if (exit_valid) begin
            r_skid <= exit_gain;
        end
    end

    assign o_valid = r_out_valid;
    assign o_gain  = r_out;

    a_rlen_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> f_valid[FROOT_W])
        else $error("right vector length not settled when an item needs it");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output register is empty");

    a_half_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_valid |-> (({1'b0, r_s6_hl} + {1'b0, r_s6_hr}) == spd_pkg::UNITY ||
                        ({1'b0, r_s6_hl} + {1'b0, r_s6_hr}) == spd_pkg::UNITY - 17'd1))
        else $error("half weights do not add up to one");

    a_att_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_valid |-> ({1'b0, r_s6_att} <= spd_pkg::UNITY))
        else $error("attenuation above unity");

endmodule
